// ===== design/tto_pkg.sv =====
// ----------------------------------------------------------------------------
// tto_pkg
// Shared types, constants and the 5x7 font for the OLED text renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tto_pkg;

  // Display geometry
  localparam int COLUMNS     = 128;
  localparam int PAGES       = 8;
  localparam int GLYPH_WIDTH = 5;
  localparam int PAGE_W      = 3;
  localparam int COL_W       = 8;

  // Beats per item: six window commands plus five glyph columns and a spacer
  localparam int MAX_BEATS = 12;
  localparam int CNT_W     = 4;
  localparam int WIN_BEATS = 6;
  localparam int CHR_BEATS = GLYPH_WIDTH + 1;

  // Opcodes
  localparam logic [1:0] OP_PRINT    = 2'd0;
  localparam logic [1:0] OP_CURSOR   = 2'd1;
  localparam logic [1:0] OP_CONTRAST = 2'd2;

  // Controller commands
  localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [7:0] CMD_CONTRAST  = 8'h81;

  // Character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] FIRST_GLYPH  = 8'h20;
  localparam logic [7:0] LAST_GLYPH   = 8'h7E;
  localparam int         NUM_GLYPHS   = 95;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [7:0] target_page;
    logic [7:0] target_column;
    logic [7:0] contrast_value;
  } in_t;

  typedef struct packed {
    logic       is_command;
    logic [7:0] payload_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  column;
  } cursor_t;

  // Byte list for one item; slot 0 goes out first
  typedef struct packed {
    logic [CNT_W-1:0]            count;
    logic [MAX_BEATS-1:0]        cmd;
    logic [MAX_BEATS-1:0][7:0]   data;
  } plan_t;

  // Glyph columns, column 0 in the top byte
  localparam logic [39:0] FONT [NUM_GLYPHS] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700,
    40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001c224100,
    40'h0041221c00, 40'h14083E0814, 40'h08083E0808,
    40'h0000A06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513E,
    40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h55AA55AA55, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0003050000, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
    40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'hFC24242418,
    40'h18242418FC, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
    40'h4464544C44, 40'h00107C8200, 40'h0000FF0000,
    40'h00827C1000, 40'h0006090906
  };

endpackage

`default_nettype wire

// ===== design/text_to_oled_page_byte_stream_top.sv =====
// ----------------------------------------------------------------------------
// text_to_oled_page_byte_stream_top
// Text renderer for a page-addressed OLED: opcodes in, command/data bytes out.
// ----------------------------------------------------------------------------
// Path: an accepted item enters the shift register, then the output register.
// Throughput: one byte per cycle unless out_stall_i holds the output; an item
//   with n bytes (2, 6 or 12) holds the input until its final byte leaves the
//   single byte-list shift register; an item with no bytes emits nothing.
// Reset: page and column cursors go to 0 and the byte pipeline empties.
`timescale 1ns / 1ps
`default_nettype none

module text_to_oled_page_byte_stream_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // input channel
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire tto_pkg::in_t   in_beat_i,
  // output channel, one beat per transmitted byte
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output tto_pkg::out_t       out_beat_o
);

  // Cursor state lives here; decode reads it and proposes the next value.
  tto_pkg::cursor_t cur_q;
  tto_pkg::cursor_t cur_d;
  tto_pkg::plan_t   plan;
  logic             take;
  logic             accept;

  // Decode is pure logic: the full byte list of the item is built in the
  // accept cycle and captured by the emitter's shift register.
  tto_decode u_decode (
    .item_i (in_beat_i),
    .cur_i  (cur_q),
    .plan_o (plan),
    .next_o (cur_d)
  );

  // Emitter frees its slot as the final byte moves to the output register,
  // so items run back to back without a gap.
  assign in_stall_o = !take;
  assign accept     = in_valid_i && take;

  // Cursor advances at accept; the next item sees the updated position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (accept) begin
      cur_q <= cur_d;
    end
  end

  tto_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .plan_i      (plan),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

// ===== design/tto_decode.sv =====
// ----------------------------------------------------------------------------
// tto_decode
// Turns one input beat and the cursor into its byte list and next cursor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tto_decode (
  input  wire tto_pkg::in_t     item_i,
  input  wire tto_pkg::cursor_t cur_i,
  output tto_pkg::plan_t        plan_o,
  output tto_pkg::cursor_t      next_o
);

  logic [tto_pkg::COL_W:0]      col_end;
  logic                         is_nl;
  logic                         wrap;
  logic [tto_pkg::PAGE_W-1:0]   wrap_page;
  logic                         has_glyph;
  logic [6:0]                   font_idx;
  logic [39:0]                  cols;
  logic                         cur_ok;
  logic [tto_pkg::PAGE_W-1:0]   win_page;
  logic [tto_pkg::COL_W-1:0]    win_col;
  logic [tto_pkg::COL_W-1:0]    base_col;
  logic [5:0][7:0]              win;
  logic [5:0][7:0]              gly;

  always_comb begin
    col_end   = {1'b0, cur_i.column} + (tto_pkg::COL_W+1)'(tto_pkg::GLYPH_WIDTH);
    is_nl     = (item_i.char_code == tto_pkg::CHAR_NEWLINE);
    wrap      = is_nl || (col_end >= (tto_pkg::COL_W+1)'(tto_pkg::COLUMNS));
    wrap_page = (cur_i.page == tto_pkg::PAGE_W'(tto_pkg::PAGES - 1)) ? '0
                                                                     : cur_i.page + 1'b1;
    has_glyph = (item_i.char_code >= tto_pkg::FIRST_GLYPH) &&
                (item_i.char_code <= tto_pkg::LAST_GLYPH);
    font_idx  = has_glyph ? 7'(item_i.char_code - tto_pkg::FIRST_GLYPH) : '0;
    cols      = has_glyph ? tto_pkg::FONT[font_idx] : '0;
    cur_ok    = (item_i.target_page < 8'(tto_pkg::PAGES)) &&
                ({1'b0, item_i.target_column} < 9'(tto_pkg::COLUMNS));

    // Window sequence uses the cursor as it stands after the move
    if (item_i.opcode == tto_pkg::OP_CURSOR) begin
      win_page = item_i.target_page[tto_pkg::PAGE_W-1:0];
      win_col  = item_i.target_column;
    end else begin
      win_page = wrap_page;
      win_col  = '0;
    end
    win[0] = tto_pkg::CMD_COL_ADDR;
    win[1] = win_col;
    win[2] = 8'(tto_pkg::COLUMNS - 1);
    win[3] = tto_pkg::CMD_PAGE_ADDR;
    win[4] = 8'(win_page);
    win[5] = 8'(tto_pkg::PAGES - 1);

    for (int k = 0; k < tto_pkg::GLYPH_WIDTH; k++) begin
      gly[k] = cols[8*(tto_pkg::GLYPH_WIDTH-1-k) +: 8];
    end
    gly[5] = 8'h00;

    base_col = wrap ? '0 : cur_i.column;

    plan_o = '0;
    next_o = cur_i;
    unique case (item_i.opcode)
      tto_pkg::OP_PRINT: begin
        for (int k = 0; k < 6; k++) begin
          plan_o.data[k]   = wrap ? win[k] : gly[k];
          plan_o.cmd[k]    = wrap;
          plan_o.data[k+6] = gly[k];
          plan_o.cmd[k+6]  = 1'b0;
        end
        plan_o.count = (wrap ? tto_pkg::CNT_W'(tto_pkg::WIN_BEATS) : '0) +
                       (is_nl ? '0 : tto_pkg::CNT_W'(tto_pkg::CHR_BEATS));
        if (wrap) begin
          next_o.page   = wrap_page;
          next_o.column = '0;
        end
        if (!is_nl) begin
          next_o.column = base_col + tto_pkg::COL_W'(tto_pkg::CHR_BEATS);
        end
      end
      tto_pkg::OP_CURSOR: begin
        if (cur_ok) begin
          for (int k = 0; k < 6; k++) begin
            plan_o.data[k] = win[k];
            plan_o.cmd[k]  = 1'b1;
          end
          plan_o.count  = tto_pkg::CNT_W'(tto_pkg::WIN_BEATS);
          next_o.page   = win_page;
          next_o.column = win_col;
        end
      end
      tto_pkg::OP_CONTRAST: begin
        plan_o.data[0] = tto_pkg::CMD_CONTRAST;
        plan_o.data[1] = item_i.contrast_value;
        plan_o.cmd[0]  = 1'b1;
        plan_o.cmd[1]  = 1'b1;
        plan_o.count   = tto_pkg::CNT_W'(2);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/tto_emit.sv =====
// ----------------------------------------------------------------------------
// tto_emit
// Holds one item's byte list and shifts it into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tto_emit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  wire tto_pkg::plan_t  plan_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output tto_pkg::out_t        out_beat_o
);

  logic [tto_pkg::CNT_W-1:0]              rem_q;
  logic [tto_pkg::MAX_BEATS-1:0]          cmd_q;
  logic [tto_pkg::MAX_BEATS-1:0][7:0]     data_q;
  logic                                   out_valid_q;
  tto_pkg::out_t                          beat_q;
  logic                                   busy;
  logic                                   out_free;
  logic                                   load_out;

  assign busy     = (rem_q != '0);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = busy && out_free;
  // next item may enter as the final beat of this one moves out
  assign take_o   = !busy || (load_out && (rem_q == tto_pkg::CNT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= plan_i.count;
    end else if (load_out) begin
      rem_q <= rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cmd_q  <= plan_i.cmd;
      data_q <= plan_i.data;
    end else if (load_out) begin
      cmd_q  <= cmd_q >> 1;
      data_q <= data_q >> 8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      beat_q.is_command   <= cmd_q[0];
      beat_q.payload_byte <= data_q[0];
      beat_q.last         <= (rem_q == tto_pkg::CNT_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = beat_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= tto_pkg::CNT_W'(tto_pkg::MAX_BEATS))
    else $error("beat count out of range");

  a_pending_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && !out_valid_q |=> out_valid_q)
    else $error("pending beat did not reach output");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && (rem_q == tto_pkg::CNT_W'(1)) |-> take_o)
    else $error("final beat did not free the item slot");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> take_o)
    else $error("item loaded over unfinished item");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the OLED text renderer. Print, set cursor and
// contrast items are pushed through the input channel, each expected byte is
// worked out by a cursor-tracking predictor, and each output beat is matched
// in order against it. Both channels idle at random outside the full-rate test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // Opcode with no function; the block drops it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Watchdog: ~100 items at up to 12 beats, each beat may wait out a few
  // stalled cycles, plus sender gaps. Far below this in any correct run.
  localparam int CYCLE_LIMIT = 200000;

  // Idle rate on either side, in percent
  localparam int GAP_PCT = 10;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // --------------------------------------------------------------------------
  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid;
  logic          in_stall;
  tto_pkg::in_t  in_beat;
  logic          out_valid;
  logic          out_stall;
  tto_pkg::out_t out_beat;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  text_to_oled_page_byte_stream_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  // --------------------------------------------------------------------------
  // Font table, column 0 in the top byte. Kept here on its own so that a bad
  // table in the design cannot hide behind a shared one.
  // --------------------------------------------------------------------------
  logic [39:0] glyph_rom [tto_pkg::NUM_GLYPHS] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083E0814, 40'h08083E0808, 40'h0000A06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513E, 40'h7C1211127C, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h18A4A4A47C, 40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
    40'h4464544C44, 40'h00107C8200, 40'h0000FF0000, 40'h00827C1000, 40'h0006090906
  };

  // --------------------------------------------------------------------------
  // Predictor state: the cursor as the block should hold it
  // --------------------------------------------------------------------------
  logic [2:0]    cur_page;
  logic [7:0]    cur_col;
  tto_pkg::out_t pending_bytes[$];   // bytes still owed by the block, oldest first

  bit gaps_on;                    // random idling on both channels
  int fail_count;
  int cycle_count;
  int items_sent;
  int beats_checked;
  int line_wraps;

  // Append one item's byte run to the pending list, flagging its final byte.
  task automatic render_item(input tto_pkg::in_t it);
    tto_pkg::out_t run [tto_pkg::MAX_BEATS];
    int   n;
    int   idx;
    bit   newline;
    n = 0;

    case (it.opcode)
      tto_pkg::OP_PRINT: begin
        newline = (it.char_code == tto_pkg::CHAR_NEWLINE);
        // Newline or glyph past the right edge: next page, column 0
        if (newline || int'(cur_col) + tto_pkg::GLYPH_WIDTH >= tto_pkg::COLUMNS) begin
          cur_page = (int'(cur_page) + 1 >= tto_pkg::PAGES) ? 3'd0 : cur_page + 3'd1;
          cur_col  = 8'd0;
          line_wraps++;
          run[0] = '{1'b1, tto_pkg::CMD_COL_ADDR, 1'b0};
          run[1] = '{1'b1, cur_col, 1'b0};
          run[2] = '{1'b1, 8'(tto_pkg::COLUMNS - 1), 1'b0};
          run[3] = '{1'b1, tto_pkg::CMD_PAGE_ADDR, 1'b0};
          run[4] = '{1'b1, {5'd0, cur_page}, 1'b0};
          run[5] = '{1'b1, 8'(tto_pkg::PAGES - 1), 1'b0};
          n = 6;
        end
        if (!newline) begin
          // Codes outside the font print as blank columns
          idx = int'(it.char_code) - int'(tto_pkg::FIRST_GLYPH);
          for (int k = 0; k < tto_pkg::GLYPH_WIDTH; k++) begin
            if (it.char_code >= tto_pkg::FIRST_GLYPH && it.char_code <= tto_pkg::LAST_GLYPH)
              run[n] = '{1'b0, glyph_rom[idx][39 - 8*k -: 8], 1'b0};
            else
              run[n] = '{1'b0, 8'h00, 1'b0};
            n++;
          end
          run[n] = '{1'b0, 8'h00, 1'b0};  // spacer column
          n++;
          cur_col = cur_col + 8'(tto_pkg::GLYPH_WIDTH + 1);
        end
      end
      tto_pkg::OP_CURSOR: begin
        // Out-of-range target: no change, no bytes
        if (it.target_page < tto_pkg::PAGES && it.target_column < tto_pkg::COLUMNS) begin
          cur_page = it.target_page[2:0];
          cur_col  = it.target_column;
          run[0] = '{1'b1, tto_pkg::CMD_COL_ADDR, 1'b0};
          run[1] = '{1'b1, cur_col, 1'b0};
          run[2] = '{1'b1, 8'(tto_pkg::COLUMNS - 1), 1'b0};
          run[3] = '{1'b1, tto_pkg::CMD_PAGE_ADDR, 1'b0};
          run[4] = '{1'b1, {5'd0, cur_page}, 1'b0};
          run[5] = '{1'b1, 8'(tto_pkg::PAGES - 1), 1'b0};
          n = 6;
        end
      end
      tto_pkg::OP_CONTRAST: begin
        run[0] = '{1'b1, tto_pkg::CMD_CONTRAST, 1'b0};
        run[1] = '{1'b1, it.contrast_value, 1'b0};
        n = 2;
      end
      default: ;  // unused opcode: dropped
    endcase

    for (int k = 0; k < n; k++) begin
      run[k].last = (k == n - 1);
      pending_bytes.push_back(run[k]);
    end
  endtask

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Input side. Called at a rising edge; returns at the edge that took the
  // beat. A gap lowers valid and waits on the clock before raising it, so
  // valid never sees two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic send_item(input tto_pkg::in_t it);
    if (gaps_on && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= it;
    do @(posedge clk_i); while (in_stall);
    render_item(it);
    items_sent++;
  endtask

  // Unused fields get random noise so that every bit toggles.
  function automatic tto_pkg::in_t make_item(input logic [1:0] op, input logic [7:0] ch,
                                             input logic [7:0] pg, input logic [7:0] col,
                                             input logic [7:0] cv);
    tto_pkg::in_t it;
    it = tto_pkg::in_t'({$urandom, $urandom});
    it.opcode = op;
    if (op == tto_pkg::OP_PRINT)    it.char_code      = ch;
    if (op == tto_pkg::OP_CURSOR)   {it.target_page, it.target_column} = {pg, col};
    if (op == tto_pkg::OP_CONTRAST) it.contrast_value = cv;
    return it;
  endfunction

  // Mostly printable text with a sprinkling of newlines, cursor moves and
  // contrast writes; the rest is junk characters, bad cursors and opcode 3.
  function automatic tto_pkg::in_t random_item();
    tto_pkg::in_t it;
    int           pick;
    it   = tto_pkg::in_t'({$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 60) begin
      it.opcode = tto_pkg::OP_PRINT;
      case ($urandom_range(9))
        0:       it.char_code = tto_pkg::CHAR_NEWLINE;
        1:       it.char_code = 8'($urandom);
        default: it.char_code = 8'($urandom_range(tto_pkg::FIRST_GLYPH,
                                                  tto_pkg::LAST_GLYPH));
      endcase
    end else if (pick < 75) begin
      it.opcode = tto_pkg::OP_CURSOR;
      if ($urandom_range(3) != 0) begin
        it.target_page   = 8'($urandom_range(tto_pkg::PAGES - 1));
        it.target_column = 8'($urandom_range(tto_pkg::COLUMNS - 1));
      end
    end else if (pick < 92) begin
      it.opcode = tto_pkg::OP_CONTRAST;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  // Lower valid, let every owed byte arrive, then give an item that produced
  // nothing time to clear the block.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Glyph edges, the all-ones column, codes with no glyph, newline
  task automatic test_print_chars();
    logic [7:0] chars [10] = '{8'h41, 8'h20, 8'h7E, 8'h7C, 8'h00,
                               8'h1F, 8'h7F, 8'h80, 8'hFF, 8'h0A};
    foreach (chars[i])
      send_item(make_item(tto_pkg::OP_PRINT, chars[i], 8'h0, 8'h0, 8'h0));
    drain();
  endtask

  // Corner positions, rejected targets, right-edge wrap and page wrap
  task automatic test_cursor_moves();
    send_item(make_item(tto_pkg::OP_CURSOR, 8'h0, 8'd0,   8'd0,   8'h0));
    send_item(make_item(tto_pkg::OP_CURSOR, 8'h0, 8'd7,   8'd127, 8'h0));
    send_item(make_item(tto_pkg::OP_CURSOR, 8'h0, 8'd8,   8'd0,   8'h0));   // page too big
    send_item(make_item(tto_pkg::OP_CURSOR, 8'h0, 8'd255, 8'd255, 8'h0));
    send_item(make_item(tto_pkg::OP_CURSOR, 8'h0, 8'd0,   8'd128, 8'h0));   // column too big
    // still at page 7 col 127: the glyph won't fit, page wraps to 0
    send_item(make_item(tto_pkg::OP_PRINT,  8'h78, 8'h0, 8'h0, 8'h0));
    // last column where a glyph still fits, then the next one wraps
    send_item(make_item(tto_pkg::OP_CURSOR, 8'h0, 8'd3,   8'd122, 8'h0));
    send_item(make_item(tto_pkg::OP_PRINT,  8'h42, 8'h0, 8'h0, 8'h0));
    send_item(make_item(tto_pkg::OP_PRINT,  8'h43, 8'h0, 8'h0, 8'h0));
    drain();
  endtask

  task automatic test_contrast_and_unused();
    send_item(make_item(tto_pkg::OP_CONTRAST, 8'h0, 8'h0, 8'h0, 8'h00));
    send_item(make_item(tto_pkg::OP_CONTRAST, 8'h0, 8'h0, 8'h0, 8'hFF));
    send_item(make_item(tto_pkg::OP_CONTRAST, 8'h0, 8'h0, 8'h0, 8'hA5));
    send_item(tto_pkg::in_t'({OP_UNUSED, 32'hFFFF_FFFF}));
    send_item(make_item(tto_pkg::OP_CONTRAST, 8'h0, 8'h0, 8'h0, 8'h5A));
    drain();
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_item(random_item());
    drain();
  endtask

  // Back-to-back on both sides, no idling at all
  task automatic test_full_rate(input int count);
    gaps_on = 1'b0;
    repeat (count) send_item(random_item());
    drain();
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Output side: check the beat taken at this edge, then pick the next stall
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tto_pkg::out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      beats_checked++;
      if (pending_bytes.size() == 0) begin
        note_fail($sformatf("unexpected beat cmd=%0b byte=%02h last=%0b",
                            out_beat.is_command, out_beat.payload_byte, out_beat.last));
      end else begin
        want = pending_bytes.pop_front();
        if (out_beat.is_command !== want.is_command)
          note_fail($sformatf("is_command exp %0b got %0b",
                              want.is_command, out_beat.is_command));
        if (out_beat.payload_byte !== want.payload_byte)
          note_fail($sformatf("payload_byte exp %02h got %02h",
                              want.payload_byte, out_beat.payload_byte));
        if (out_beat.last !== want.last)
          note_fail($sformatf("last exp %0b got %0b", want.last, out_beat.last));
      end
    end
    out_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    in_valid      <= 1'b0;
    in_beat       <= '0;
    out_stall     <= 1'b0;
    gaps_on       = 1'b1;
    fail_count    = 0;
    items_sent    = 0;
    beats_checked = 0;
    line_wraps    = 0;
    cur_page      = 3'd0;
    cur_col       = 8'd0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_print_chars();
    test_cursor_moves();
    test_contrast_and_unused();
    test_random_traffic(50);
    test_full_rate(26);

    repeat (20) @(posedge clk_i);
    if (pending_bytes.size() != 0)
      note_fail($sformatf("%0d bytes never arrived", pending_bytes.size()));

    $display("Run covered %0d items, %0d output beats, %0d page advances.",
             items_sent, beats_checked, line_wraps);
    $display("Mismatches seen: %0d", fail_count);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
